>>> design/mkde_pkg.sv
// Shared constants and types for the multi-key debounce event block.
package mkde_pkg;

    // Key count and counter limits
    localparam int NUM_KEYS    = 4;
    localparam int COUNT_LIMIT = 250;
    localparam int MAX_EVENTS  = 4;

    // Field widths
    localparam int CNT_W     = 8;
    localparam int KEY_W     = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int EVT_CNT_W = $clog2(MAX_EVENTS + 1);
    localparam int CFG_DW    = CNT_W;
    localparam int CFG_IW    = 1;

    // Configuration register indexes
    localparam logic [CFG_IW-1:0] REG_RELEASE_LEVELS = 1'd0;
    localparam logic [CFG_IW-1:0] REG_CONFIRM_COUNT  = 1'd1;

    // Reset values of the configuration registers
    localparam logic [NUM_KEYS-1:0] RELEASE_LEVELS_RST = NUM_KEYS'(14);
    localparam logic [CNT_W-1:0]    CONFIRM_COUNT_RST  = CNT_W'(2);

    // Event codes
    localparam logic EVT_RELEASE = 1'b0;
    localparam logic EVT_PRESS   = 1'b1;

    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [NUM_KEYS-1:0] key_mask_t;

endpackage

>>> design/multi_key_debounce_events_top.sv
// Top level of the multi-key debouncer: counters, event queue and output stage.
//
// Usage:
//   Input channel (in_valid/in_ready/pin_levels) carries one scan tick per
//   transaction with the sampled level of every key. On acceptance all key
//   counters update in the same cycle and the confirmed events of the tick are
//   captured in a pending-event register.
//   Output channel (out_valid/out_ready) presents one event per transaction,
//   lowest key first: key_index, key_event (0 release, 1 press) and
//   last_event on the final event of the tick. A tick with no event yields
//   no transaction.
//   The first event of a tick is valid in the cycle after the tick is
//   accepted. The single output register drains one event per cycle while
//   out_ready is high; the next tick is accepted in the same cycle its
//   predecessor's last event is taken, so quiet ticks flow at one per
//   cycle.
//   Configuration: cfg_wr_en writes cfg_data into register cfg_index
//   (0 release levels, 1 confirm count) at once; write only while idle.
//   Reset clears all counters and pending events and loads release levels 14
//   and confirm count 2. When the receiver stalls, the current event holds
//   and no new tick is accepted until the last event of the tick is taken.
module multi_key_debounce_events_top
    import mkde_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [CFG_IW-1:0]   cfg_index,
    input  logic [CFG_DW-1:0]   cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [NUM_KEYS-1:0] pin_levels,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [KEY_W-1:0]    key_index,
    output logic                key_event,
    output logic                last_event
);

    localparam logic [CNT_W:0] LIMIT_EXT = (CNT_W+1)'(COUNT_LIMIT);

    key_mask_t release_levels_reg;
    cnt_t      confirm_count_reg;
    cnt_t      press_cnt_reg [NUM_KEYS];
    cnt_t      rel_cnt_reg   [NUM_KEYS];
    cnt_t      press_cnt_next[NUM_KEYS];
    cnt_t      rel_cnt_next  [NUM_KEYS];
    key_mask_t pend_mask_reg;
    key_mask_t pend_mask_next;
    key_mask_t pend_type_reg;
    key_mask_t pend_type_next;
    key_mask_t fire_mask;
    key_mask_t type_mask;
    logic      in_fire;
    logic      out_fire;

    // Update counters and collect confirmed events for the incoming tick
    always_comb
    begin
        logic [CNT_W:0]     bump;
        logic               hit;
        logic [EVT_CNT_W-1:0] n_evt;
        n_evt = '0;
        fire_mask = '0;
        type_mask = '0;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            press_cnt_next[k] = press_cnt_reg[k];
            rel_cnt_next[k]   = rel_cnt_reg[k];
            if (pin_levels[k] == release_levels_reg[k])
            begin
                bump = {1'b0, rel_cnt_reg[k]} + 1'b1;
                hit  = (bump == {1'b0, confirm_count_reg});
                rel_cnt_next[k] = (bump >= LIMIT_EXT) ? CNT_W'(COUNT_LIMIT) : bump[CNT_W-1:0];
                if (hit)
                begin
                    press_cnt_next[k] = '0;
                end
                type_mask[k] = EVT_RELEASE;
            end
            else
            begin
                bump = {1'b0, press_cnt_reg[k]} + 1'b1;
                hit  = (bump == {1'b0, confirm_count_reg});
                press_cnt_next[k] = (bump >= LIMIT_EXT) ? CNT_W'(COUNT_LIMIT) : bump[CNT_W-1:0];
                if (hit)
                begin
                    rel_cnt_next[k] = '0;
                end
                type_mask[k] = EVT_PRESS;
            end
            // Drop events beyond the per-tick limit
            if (hit && (n_evt < EVT_CNT_W'(MAX_EVENTS)))
            begin
                fire_mask[k] = 1'b1;
                n_evt = n_evt + 1'b1;
            end
        end
    end

    // Present the lowest pending event
    always_comb
    begin
        key_index = '0;
        for (int k = NUM_KEYS - 1; k >= 0; k--)
        begin
            if (pend_mask_reg[k])
            begin
                key_index = KEY_W'(k);
            end
        end
    end

    assign out_valid  = |pend_mask_reg;
    assign key_event  = pend_type_reg[key_index];
    assign last_event = ((pend_mask_reg & (pend_mask_reg - 1'b1)) == '0);
    assign out_fire   = out_valid && out_ready;
    assign in_ready   = !out_valid || (out_ready && last_event);
    assign in_fire    = in_valid && in_ready;

    // Load a new tick's events or retire the event just taken
    always_comb
    begin
        pend_mask_next = pend_mask_reg;
        pend_type_next = pend_type_reg;
        if (in_fire)
        begin
            pend_mask_next = fire_mask;
            pend_type_next = type_mask;
        end
        else if (out_fire)
        begin
            pend_mask_next = pend_mask_reg & (pend_mask_reg - 1'b1);
        end
    end

    // Hold configuration, counters and pending events
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            release_levels_reg <= RELEASE_LEVELS_RST;
            confirm_count_reg  <= CONFIRM_COUNT_RST;
            pend_mask_reg      <= '0;
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                press_cnt_reg[k] <= '0;
                rel_cnt_reg[k]   <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_RELEASE_LEVELS: release_levels_reg <= cfg_data[NUM_KEYS-1:0];
                    REG_CONFIRM_COUNT:  confirm_count_reg  <= cfg_data;
                    default: ;
                endcase
            end
            pend_mask_reg <= pend_mask_next;
            if (in_fire)
            begin
                for (int k = 0; k < NUM_KEYS; k++)
                begin
                    press_cnt_reg[k] <= press_cnt_next[k];
                    rel_cnt_reg[k]   <= rel_cnt_next[k];
                end
            end
        end
    end

    // Event types need no reset
    always_ff @(posedge clk)
    begin
        pend_type_reg <= pend_type_next;
    end

    // A non-final event taken leaves another event of the same tick behind
    assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && !last_event |=> out_valid)
        else $error("event queue emptied before the last event");

    // Events of one tick come out in rising key order
    assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && !last_event |=> key_index > $past(key_index))
        else $error("events out of key order");

    // A tick is taken only when no event other than the final one is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && out_valid |-> out_fire && last_event)
        else $error("tick accepted over pending events");

    // The counters of key 0 never pass the saturation limit
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (press_cnt_reg[0] <= CNT_W'(COUNT_LIMIT))
                 && (rel_cnt_reg[0] <= CNT_W'(COUNT_LIMIT)))
        else $error("counter above limit");

endmodule
